// ===== design/rgb_to_hsv_converter_unit_macros.svh =====
// Assertion macros shared by the RGB to HSV converter RTL.
// Has no dependencies; include it inside the modules that carry assertions.
`ifndef RGB_TO_HSV_CONVERTER_UNIT_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RHSV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rhsv: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RHSV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rhsv: next-cycle check failed");

`endif

// ===== design/rhsv_pkg.sv =====
// Package for the RGB to HSV converter: widths, scale constants, sector codes
// and the payload and pipeline structs. No dependencies.
package rhsv_pkg;

    localparam int CH_W     = 8;   // color channel width
    localparam int HUE_W    = 9;   // hue in degrees, 0..359
    localparam int PCT_W    = 7;   // percent, 0..100
    localparam int NUM_W    = 15;  // divider numerator width (max 25500)
    localparam int DIV_BITS = 7;   // quotient bits, one per divider stage
    localparam int SUM_W    = 16;  // width of the divide-by-255 correction sum

    localparam logic [NUM_W-1:0] PCT_SCALE  = NUM_W'(100);
    localparam logic [NUM_W-1:0] HUE_SECTOR = NUM_W'(60);

    localparam logic [HUE_W-1:0] HUE_BASE_RED   = HUE_W'(0);
    localparam logic [HUE_W-1:0] HUE_BASE_GREEN = HUE_W'(120);
    localparam logic [HUE_W-1:0] HUE_BASE_BLUE  = HUE_W'(240);
    localparam logic [HUE_W-1:0] HUE_FULL_TURN  = HUE_W'(360);

    typedef logic [1:0] sector_t;
    localparam sector_t SECT_RED   = 2'd0;
    localparam sector_t SECT_GREEN = 2'd1;
    localparam sector_t SECT_BLUE  = 2'd2;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] saturation;
        logic [PCT_W-1:0] brightness_value;
    } hsv_t;

    // Everything the final stage needs besides the two quotients and the hue remainder flag.
    typedef struct packed {
        sector_t          sector;
        logic             n_neg;
        logic             grey;
        logic             black;
        logic [PCT_W-1:0] val;
    } side_t;

    typedef struct packed {
        logic [NUM_W-1:0] num_sat;
        logic [CH_W-1:0]  den_sat;
        logic [NUM_W-1:0] num_hue;
        logic [CH_W-1:0]  den_hue;
    } div_in_t;

    typedef struct packed {
        logic [DIV_BITS-1:0] q_sat;
        logic [DIV_BITS-1:0] q_hue;
        logic                hue_rem_nz;
    } div_out_t;

endpackage

// ===== design/rhsv_div.sv =====
// Pipelined dual restoring divider for saturation and hue, one quotient bit per stage.
// Depends on rhsv_pkg.
module rhsv_div
    import rhsv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     in_valid,
    input  div_in_t  din,
    input  side_t    side_in,
    output logic     out_valid,
    output div_out_t dout,
    output side_t    side_out
);

    typedef struct packed {
        logic [NUM_W-1:0]    rem_sat;
        logic [CH_W-1:0]     den_sat;
        logic [DIV_BITS-1:0] q_sat;
        logic [NUM_W-1:0]    rem_hue;
        logic [CH_W-1:0]     den_hue;
        logic [DIV_BITS-1:0] q_hue;
        side_t               side;
    } stage_t;

    stage_t                stage_reg  [1:DIV_BITS];
    stage_t                stage_next [1:DIV_BITS];
    logic   [DIV_BITS:1]   vld_reg;
    stage_t                cur        [0:DIV_BITS-1];
    logic   [DIV_BITS-1:0] vld_cur;

    // Stage inputs: the first stage takes the port, the others the previous register.
    always_comb
    begin
        cur[0].rem_sat = din.num_sat;
        cur[0].den_sat = din.den_sat;
        cur[0].q_sat   = '0;
        cur[0].rem_hue = din.num_hue;
        cur[0].den_hue = din.den_hue;
        cur[0].q_hue   = '0;
        cur[0].side    = side_in;
        vld_cur[0]     = in_valid;
        for (int k = 1; k < DIV_BITS; k++)
        begin
            cur[k]     = stage_reg[k];
            vld_cur[k] = vld_reg[k];
        end
    end

    // Each stage tries the divisor shifted to its own quotient bit.
    always_comb
    begin
        logic [NUM_W-1:0] dsh_sat;
        logic [NUM_W-1:0] dsh_hue;
        for (int j = 0; j < DIV_BITS; j++)
        begin
            stage_next[j+1] = cur[j];
            dsh_sat = NUM_W'(cur[j].den_sat) << (DIV_BITS - 1 - j);
            dsh_hue = NUM_W'(cur[j].den_hue) << (DIV_BITS - 1 - j);
            if (cur[j].rem_sat >= dsh_sat)
            begin
                stage_next[j+1].rem_sat                  = cur[j].rem_sat - dsh_sat;
                stage_next[j+1].q_sat[DIV_BITS - 1 - j] = 1'b1;
            end
            if (cur[j].rem_hue >= dsh_hue)
            begin
                stage_next[j+1].rem_hue                  = cur[j].rem_hue - dsh_hue;
                stage_next[j+1].q_hue[DIV_BITS - 1 - j] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_cur;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 1; k <= DIV_BITS; k++)
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign out_valid       = vld_reg[DIV_BITS];
    assign dout.q_sat      = stage_reg[DIV_BITS].q_sat;
    assign dout.q_hue      = stage_reg[DIV_BITS].q_hue;
    assign dout.hue_rem_nz = |stage_reg[DIV_BITS].rem_hue;
    assign side_out        = stage_reg[DIV_BITS].side;

endmodule

// ===== design/rgb_to_hsv_converter_unit.sv =====
// Top level of the RGB to HSV converter: channel sorting, scaling, divider pipeline
// and output register. Depends on rhsv_pkg, rhsv_div and the assertion macro header.
//
//   Channel   Signals                        Direction  Item
//   pixel     pix_valid, pix_ready, pix      in         pixel_t (red, green, blue)
//   result    hsv_valid, hsv_ready, hsv      out        hsv_t (hue, saturation, value)
//
// Throughput is one item per clock unless hsv_ready stalls the output. An accepted item
// passes the sort, scale and seven divider stages and the output register to hsv_valid.
// The seven-stage restoring divider, one quotient bit per stage, sets the depth.
// Reset clears only the valid bits; payload registers hold whatever they last took.
// A stall at the output freezes every stage together, so no item is lost or repeated.
`include "rgb_to_hsv_converter_unit_macros.svh"

module rgb_to_hsv_converter_unit
    import rhsv_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   pix_valid,
    output logic   pix_ready,
    input  pixel_t pix,
    output logic   hsv_valid,
    input  logic   hsv_ready,
    output hsv_t   hsv
);

    // The whole pipeline advances whenever the output register is empty or being drained.
    logic en;

    // Stage 1: largest channel, spread and the signed numerator of the hue sector.
    logic            s1_valid_reg;
    logic [CH_W-1:0] mx_reg, mx_next;
    logic [CH_W-1:0] d_reg, d_next;
    sector_t         sector_reg, sector_next;
    logic [CH_W-1:0] n_abs_reg, n_abs_next;
    logic            n_neg_reg, n_neg_next;

    // Stage 2: scaled numerators, value percentage and special-case flags.
    logic             s2_valid_reg;
    div_in_t          div_in_reg, div_in_next;
    side_t            side_reg, side_next;
    logic [NUM_W-1:0] mx_pct;
    logic [SUM_W-1:0] val_sum;

    // Divider output and the final register.
    logic      div_valid;
    div_out_t  div_out;
    side_t     div_side;
    logic      hsv_valid_reg;
    hsv_t      hsv_reg, hsv_next;
    logic [HUE_W-1:0] hue_base;
    logic [HUE_W-1:0] hue_q;

    // Every field of the held result lies inside its documented range.
    logic hsv_in_range;

    assign en        = !hsv_valid_reg || hsv_ready;
    assign pix_ready = en;

    // Ties go to red first, then green, matching the usual sector convention.
    always_comb
    begin
        logic [CH_W-1:0] mn;
        logic [CH_W-1:0] a;
        logic [CH_W-1:0] c;
        if (pix.red >= pix.green && pix.red >= pix.blue)
        begin
            sector_next = SECT_RED;
            mx_next     = pix.red;
            a           = pix.green;
            c           = pix.blue;
        end
        else if (pix.green >= pix.blue)
        begin
            sector_next = SECT_GREEN;
            mx_next     = pix.green;
            a           = pix.blue;
            c           = pix.red;
        end
        else
        begin
            sector_next = SECT_BLUE;
            mx_next     = pix.blue;
            a           = pix.red;
            c           = pix.green;
        end
        mn = (a < c) ? a : c;
        d_next     = mx_next - mn;
        n_neg_next = (a < c);
        n_abs_next = (a < c) ? (c - a) : (a - c);
    end

    // Value is floor(max * 100 / 255); the add-and-shift form is exact for sums
    // below 65535, which covers 255 * 100.
    always_comb
    begin
        mx_pct  = NUM_W'(mx_reg) * PCT_SCALE;
        val_sum = SUM_W'(mx_pct) + SUM_W'(mx_pct >> CH_W) + SUM_W'(1);

        div_in_next.num_sat = NUM_W'(d_reg) * PCT_SCALE;
        div_in_next.den_sat = mx_reg;
        div_in_next.num_hue = NUM_W'(n_abs_reg) * HUE_SECTOR;
        div_in_next.den_hue = d_reg;

        side_next.sector = sector_reg;
        side_next.n_neg  = n_neg_reg;
        side_next.grey   = (d_reg == '0);
        side_next.black  = (mx_reg == '0);
        side_next.val    = PCT_W'(val_sum >> CH_W);
    end

    rhsv_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_valid_reg),
        .din       (div_in_reg),
        .side_in   (side_reg),
        .out_valid (div_valid),
        .dout      (div_out),
        .side_out  (div_side)
    );

    // A negative numerator floors downward, so the quotient is rounded up before
    // it is taken from the base. In the red sector this wraps into 300..359.
    always_comb
    begin
        hue_q = HUE_W'(div_out.q_hue);
        case (div_side.sector)
            SECT_RED:   hue_base = div_side.n_neg ? HUE_FULL_TURN : HUE_BASE_RED;
            SECT_GREEN: hue_base = HUE_BASE_GREEN;
            SECT_BLUE:  hue_base = HUE_BASE_BLUE;
            default:    hue_base = HUE_BASE_RED;
        endcase

        if (div_side.grey)
        begin
            hsv_next.hue = '0;
        end
        else if (div_side.n_neg)
        begin
            hsv_next.hue = hue_base - hue_q - HUE_W'(div_out.hue_rem_nz);
        end
        else
        begin
            hsv_next.hue = hue_base + hue_q;
        end

        hsv_next.saturation       = div_side.black ? '0 : PCT_W'(div_out.q_sat);
        hsv_next.brightness_value = div_side.val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            hsv_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= pix_valid;
            s2_valid_reg  <= s1_valid_reg;
            hsv_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg     <= mx_next;
            d_reg      <= d_next;
            sector_reg <= sector_next;
            n_abs_reg  <= n_abs_next;
            n_neg_reg  <= n_neg_next;
            div_in_reg <= div_in_next;
            side_reg   <= side_next;
            hsv_reg    <= hsv_next;
        end
    end

    assign hsv_valid = hsv_valid_reg;
    assign hsv       = hsv_reg;

    assign hsv_in_range = (hsv_reg.hue < HUE_FULL_TURN)
                       && (hsv_reg.saturation <= PCT_W'(100))
                       && (hsv_reg.brightness_value <= PCT_W'(100));

    // Results stay inside their documented ranges.
    `RHSV_ASSERT_IMPL(a_out_range, clk, rst_n, hsv_valid_reg, hsv_in_range)
    // An accepted pixel is in the first stage on the next cycle.
    `RHSV_ASSERT_NEXT(a_accept_fill, clk, rst_n, pix_valid && pix_ready, s1_valid_reg)
    // A valid first stage moves on into the second when the pipeline advances.
    `RHSV_ASSERT_NEXT(a_s1_to_s2, clk, rst_n, s1_valid_reg && en, s2_valid_reg)

endmodule

// ===== dv/tb_rgb_to_hsv_converter_unit.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for rgb_to_hsv_converter_unit: pixels in, hue/saturation/value out.
// Depends on rhsv_pkg for the pixel_t and hsv_t payloads and on the converter RTL.

import rhsv_pkg::*;

// Holds the expected HSV results in acceptance order and compares each result
// that leaves the block against the oldest one.
class hsv_scoreboard;
    hsv_t expected_hsv[$];
    int   error_count;
    int   pixels_noted;
    int   results_checked;

    // Floor division for a positive divisor; SystemVerilog division truncates toward zero.
    function int div_floor(int num, int den);
        if (num >= 0)
            return num / den;
        return -((-num + den - 1) / den);
    endfunction

    // Exact integer conversion: each field is the floor of its rational value.
    function hsv_t convert_pixel(pixel_t p);
        int   r;
        int   g;
        int   b;
        int   mx;
        int   mn;
        int   d;
        int   h;
        hsv_t res;
        r  = p.red;
        g  = p.green;
        b  = p.blue;
        mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
        mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
        d  = mx - mn;
        res.brightness_value = PCT_W'((mx * 100) / 255);
        res.saturation       = (mx == 0) ? '0 : PCT_W'((d * 100) / mx);
        // Ties for the largest channel go to red first, then green.
        if (d == 0)
            h = 0;
        else if (mx == r)
        begin
            h = div_floor(60 * (g - b), d);
            if (g < b)
                h = h + 360;
        end
        else if (mx == g)
            h = 120 + div_floor(60 * (b - r), d);
        else
            h = 240 + div_floor(60 * (r - g), d);
        res.hue = HUE_W'(h);
        return res;
    endfunction

    function void note_pixel(pixel_t p);
        expected_hsv.push_back(convert_pixel(p));
        pixels_noted++;
    endfunction

    function void check_hsv(hsv_t got);
        hsv_t want;
        if (expected_hsv.size() == 0)
        begin
            $error("result with nothing outstanding: hue %0d saturation %0d value %0d",
                   got.hue, got.saturation, got.brightness_value);
            error_count++;
            return;
        end
        want = expected_hsv.pop_front();
        results_checked++;
        if (got.hue !== want.hue)
        begin
            $error("hue: expected %0d, actual %0d", want.hue, got.hue);
            error_count++;
        end
        if (got.saturation !== want.saturation)
        begin
            $error("saturation: expected %0d, actual %0d", want.saturation, got.saturation);
            error_count++;
        end
        if (got.brightness_value !== want.brightness_value)
        begin
            $error("brightness_value: expected %0d, actual %0d",
                   want.brightness_value, got.brightness_value);
            error_count++;
        end
    endfunction

    function int outstanding();
        return expected_hsv.size();
    endfunction
endclass

module tb_rgb_to_hsv_converter_unit;

    logic   clk = 1'b0;
    logic   rst_n;
    logic   pix_valid;
    logic   pix_ready;
    pixel_t pix;
    logic   hsv_valid;
    logic   hsv_ready;
    hsv_t   hsv;

    // Percent chance per cycle that the sender sits idle or the receiver stalls.
    int send_idle_pct;
    int recv_stall_pct;
    // Cycles left in a forced receiver hold-off; the receiver process counts it down.
    int hold_cycles_left;

    hsv_scoreboard sb;

    rgb_to_hsv_converter_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .hsv_valid (hsv_valid),
        .hsv_ready (hsv_ready),
        .hsv       (hsv)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offers one pixel and returns at the edge where it is accepted. Valid stays
    // high into the next call when no idle cycle is drawn, so back-to-back items
    // flow at full rate. All signals are sampled right after the edge, so they
    // hold the values the block saw at that edge.
    task automatic send_pixel(input pixel_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix       <= p;
        do
            @(posedge clk);
        while (!pix_ready);
        sb.note_pixel(p);
    endtask

    // The sender goes quiet until every outstanding result has been checked.
    task automatic drain_results();
        pix_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    function automatic pixel_t make_pixel(input int r, input int g, input int b);
        pixel_t p;
        p.red   = CH_W'(r);
        p.green = CH_W'(g);
        p.blue  = CH_W'(b);
        return p;
    endfunction

    // Picks a channel value near base, clamped to the 8-bit range.
    function automatic int near_value(input int base);
        int v;
        v = base + int'($urandom_range(6)) - 3;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v;
    endfunction

    function automatic int edge_value();
        case ($urandom_range(4))
            0: return 0;
            1: return 1;
            2: return 254;
            3: return 255;
            default: return int'($urandom_range(255));
        endcase
    endfunction

    // Random pixels in several flavors: uniform, nearly grey (tiny delta, so the
    // hue divisions are coarse and the floors matter most), pixels with tied
    // channels, and channels drawn from the range ends.
    function automatic pixel_t random_pixel();
        int base;
        int tie;
        base = $urandom_range(255);
        tie  = $urandom_range(255);
        case ($urandom_range(3))
            0: return make_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
            1: return make_pixel(near_value(base), near_value(base), near_value(base));
            2:
            begin
                case ($urandom_range(2))
                    0: return make_pixel(tie, tie, $urandom_range(255));
                    1: return make_pixel(tie, $urandom_range(255), tie);
                    default: return make_pixel($urandom_range(255), tie, tie);
                endcase
            end
            default: return make_pixel(edge_value(), edge_value(), edge_value());
        endcase
    endfunction

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_pixel(random_pixel());
    endtask

    // Hand-picked pixels: range ends, every hue sector, the grey and black cases,
    // all three kinds of tie for the largest channel, and the red sector wrapping
    // just below a full turn when blue exceeds green.
    task automatic send_directed();
        send_pixel(make_pixel(0, 0, 0));         // black
        send_pixel(make_pixel(255, 255, 255));   // white
        send_pixel(make_pixel(128, 128, 128));   // mid grey
        send_pixel(make_pixel(1, 1, 1));         // near-black grey
        send_pixel(make_pixel(255, 0, 0));       // pure red
        send_pixel(make_pixel(0, 255, 0));       // pure green
        send_pixel(make_pixel(0, 0, 255));       // pure blue
        send_pixel(make_pixel(255, 255, 0));     // red and green tie, red wins
        send_pixel(make_pixel(0, 255, 255));     // green and blue tie, green wins
        send_pixel(make_pixel(255, 0, 255));     // red and blue tie, hue wraps to 300
        send_pixel(make_pixel(255, 0, 1));       // red sector wraps to 359
        send_pixel(make_pixel(255, 1, 0));       // red sector just above 0
        send_pixel(make_pixel(255, 254, 253));   // small delta at full brightness
        send_pixel(make_pixel(1, 0, 0));         // dimmest red, value floors to 0
        send_pixel(make_pixel(254, 0, 0));       // value floors to 99
        send_pixel(make_pixel(200, 255, 0));     // green sector, blue below red
        send_pixel(make_pixel(0, 255, 200));     // green sector, blue above red
        send_pixel(make_pixel(10, 20, 30));      // blue sector, red below green
        send_pixel(make_pixel(30, 20, 255));     // blue sector, red above green
        send_pixel(make_pixel(0, 1, 0));         // dimmest green
        send_pixel(make_pixel(0, 0, 1));         // dimmest blue
        send_pixel(make_pixel(170, 85, 85));     // red sector, green equals blue
    endtask

    // Receiver: checks each result taken at an edge, then draws ready for the next
    // cycle. A forced hold-off keeps ready low while the sender keeps offering
    // pixels, so the pipeline fills and the block must stall its input.
    initial
    begin
        hsv_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && hsv_valid && hsv_ready)
                sb.check_hsv(hsv);
            if (hold_cycles_left > 0)
            begin
                hsv_ready <= 1'b0;
                hold_cycles_left--;
            end
            else
                hsv_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Main sequence: reset, directed pixels, four idle mixes, then the long stall.
    initial
    begin
        sb               = new();
        rst_n            = 1'b0;
        pix_valid        = 1'b0;
        pix              = '0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        hold_cycles_left = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Full rate on both sides.
        send_directed();
        send_random(200);
        drain_results();

        // Sparse sender.
        send_idle_pct  = 64;
        recv_stall_pct = 0;
        send_random(200);
        drain_results();

        // Heavily stalling receiver.
        send_idle_pct  = 0;
        recv_stall_pct = 64;
        send_random(200);
        drain_results();

        // Light idling on both sides.
        send_idle_pct  = 13;
        recv_stall_pct = 13;
        send_random(200);
        drain_results();

        // Receiver holds off while pixels keep coming.
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        hold_cycles_left = 300;
        send_random(60);
        drain_results();

        // The pipeline is 10 deep; give any stray result time to show up.
        repeat (30) @(posedge clk);

        $display("Summary: %0d pixels converted and %0d results compared, over directed",
                 sb.pixels_noted, sb.results_checked);
        $display("pixels, four idle mixes and a long output stall with a full pipeline.");
        if (sb.error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: a correct run needs well under a tenth of this.
    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
